[sv/bcdt_pkg.sv]
// Package: payload types, reset constants and BCD helper functions for the date tracker.
`default_nettype none
package bcdt_pkg;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef struct packed {
    logic       command;
    logic [5:0] hours_bcd;
    logic [6:0] minutes_bcd;
    logic [6:0] seconds_bcd;
    logic [7:0] load_year_bcd;
    logic [4:0] load_month_bcd;
    logic [5:0] load_day_bcd;
    logic [2:0] load_weekday;
  } item_t;

  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday_now;
    logic       day_advanced;
  } result_t;

  typedef struct packed {
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [2:0] weekday;
  } date_t;

  typedef struct packed {
    logic [5:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
  } tod_t;

  localparam date_t DATE_RESET = '{year: 8'h25, month: 5'h04, day: 6'h30, weekday: 3'd2};
  localparam tod_t  TOD_RESET  = '{hours: 6'h17, minutes: 7'h46, seconds: 7'h00};

  localparam logic [7:0] MONTHS_PER_YEAR = 8'd12;
  localparam logic [7:0] LAST_YEAR       = 8'd99;
  localparam logic [7:0] LEN_FEB_LEAP    = 8'd29;
  localparam logic [7:0] LEN_FEB         = 8'd28;
  localparam logic [7:0] LEN_SHORT       = 8'd30;
  localparam logic [7:0] LEN_LONG        = 8'd31;
  localparam logic [2:0] WEEKDAY_LAST    = 3'd7;
  localparam logic [2:0] WEEKDAY_FIRST   = 3'd1;

  // Decode two nibbles as high*10 + low, also for nibbles above nine.
  function automatic logic [7:0] bcd_dec(input logic [7:0] v);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0, v[7:4]};
    lo = {4'b0, v[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Encode a value below 100 as two BCD digits; divide by ten by reciprocal.
  function automatic logic [7:0] bcd_enc(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = {8'b0, v} * 15'd205;
    tens = prod[14:11];
    rem  = v - 7'({tens, 3'b0} + {2'b0, tens, 1'b0});
    return {tens, rem[3:0]};
  endfunction

endpackage
`default_nettype wire

[sv/bcdt_stream_if.sv]
// Interface: valid/ready stream channel carrying one payload struct.
`default_nettype none
interface bcdt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/bcd_calendar_date_tracker.sv]
// Top level: BCD calendar date tracker with input register, date step and result register.
// Path: an accepted item enters the input register, then the result register; a stall holds it in the input register.
// Throughput: one item per cycle while results are taken; the date step is a single short pass between registers.
// Stalls: the input register holds while the result register is full and not taken.
// Reset (rst_ni low, asynchronous): both stages empty, date 2025-04-30 weekday 2,
// stored time 17:46:00.
`default_nettype none
module bcd_calendar_date_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  bcdt_stream_if.sink   item_i,
  bcdt_stream_if.source result_o
);
  import bcdt_pkg::*;

  // Input register stage
  logic  s1_valid_q;
  item_t s1_item_q;

  // Calendar state
  date_t date_q, date_d;
  tod_t  last_q, last_d;

  // Result register stage
  logic    res_valid_q;
  result_t res_q, res_d;

  logic  advance;
  logic  earlier;
  tod_t  now_tod;
  date_t date_next;

  // Move the input register on whenever the result register is free or being drained.
  assign advance      = s1_valid_q && (!res_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || advance;

  assign now_tod = '{hours:   s1_item_q.hours_bcd,
                     minutes: s1_item_q.minutes_bcd,
                     seconds: s1_item_q.seconds_bcd};

  bcdt_midnight_cmp u_cmp (
    .now_i     (now_tod),
    .last_i    (last_q),
    .earlier_o (earlier)
  );

  bcdt_date_step u_step (
    .date_i (date_q),
    .date_o (date_next)
  );

  // Select the new date: load takes the fields as given, a sample crossing
  // midnight takes the stepped date, otherwise hold.
  always_comb begin
    logic adv;
    adv    = 1'b0;
    date_d = date_q;
    unique case (s1_item_q.command)
      CMD_LOAD: begin
        date_d = '{year:    s1_item_q.load_year_bcd,
                   month:   s1_item_q.load_month_bcd,
                   day:     s1_item_q.load_day_bcd,
                   weekday: s1_item_q.load_weekday};
      end
      CMD_SAMPLE: begin
        if (earlier) begin
          date_d = date_next;
          adv    = 1'b1;
        end
      end
      default: begin
        date_d = date_q;
      end
    endcase
    // the item's time fields always become the stored time, also on a load
    last_d = now_tod;
    res_d  = '{year_bcd:     date_d.year,
               month_bcd:    date_d.month,
               day_bcd:      date_d.day,
               weekday_now:  date_d.weekday,
               day_advanced: adv};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      date_q      <= DATE_RESET;
      last_q      <= TOD_RESET;
    end else begin
      if (item_i.ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (advance) begin
        date_q      <= date_d;
        last_q      <= last_d;
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        // drop the delivered result
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_item_q <= item_i.payload;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid   = res_valid_q;
  assign result_o.payload = res_q;

endmodule
`default_nettype wire

[sv/bcdt_midnight_cmp.sv]
// Midnight detector: flags a time sample that lies earlier than the stored time.
`default_nettype none
module bcdt_midnight_cmp (
  input  bcdt_pkg::tod_t now_i,
  input  bcdt_pkg::tod_t last_i,
  output logic           earlier_o
);
  import bcdt_pkg::*;

  logic [7:0] ch, lh, cm, lm, cs, ls;

  always_comb begin
    ch = bcd_dec({2'b0, now_i.hours});
    lh = bcd_dec({2'b0, last_i.hours});
    cm = bcd_dec({1'b0, now_i.minutes});
    lm = bcd_dec({1'b0, last_i.minutes});
    cs = bcd_dec({1'b0, now_i.seconds});
    ls = bcd_dec({1'b0, last_i.seconds});
    // compare level by level: hours, then minutes, then seconds
    earlier_o = (ch < lh) || ((ch == lh) && (cm < lm)) ||
                ((ch == lh) && (cm == lm) && (cs < ls));
  end

endmodule
`default_nettype wire

[sv/bcdt_date_step.sv]
// Date step: advance a BCD date by one day with month lengths and leap years.
`default_nettype none
module bcdt_date_step (
  input  bcdt_pkg::date_t date_i,
  output bcdt_pkg::date_t date_o
);
  import bcdt_pkg::*;

  logic [7:0] yv, mv, dv, len, mn, yn;
  logic       roll;

  always_comb begin
    yv = bcd_dec(date_i.year);
    mv = bcd_dec({3'b0, date_i.month});
    dv = bcd_dec({2'b0, date_i.day}) + 8'd1;

    priority if (mv == 8'd2) begin
      len = (yv[1:0] == 2'b00) ? LEN_FEB_LEAP : LEN_FEB;
    end else if (mv == 8'd4 || mv == 8'd6 || mv == 8'd9 || mv == 8'd11) begin
      len = LEN_SHORT;
    end else begin
      len = LEN_LONG;
    end

    roll   = dv > len;
    mn     = mv + 8'd1;
    yn     = yv + 8'd1;
    date_o = date_i;

    if (roll) begin
      date_o.day = 6'h01;
      if (mn > MONTHS_PER_YEAR) begin
        date_o.month = 5'h01;
        date_o.year  = (yn > LAST_YEAR) ? 8'h00 : bcd_enc(yn[6:0]);
      end else begin
        date_o.month = 5'(bcd_enc(mn[6:0]));
      end
    end else begin
      date_o.day = 6'(bcd_enc(dv[6:0]));
    end

    // weekday steps as (w mod 7) + 1
    date_o.weekday = (date_i.weekday == WEEKDAY_LAST) ? WEEKDAY_FIRST
                                                      : date_i.weekday + 3'd1;
  end

endmodule
`default_nettype wire
